@@ rtl/core/assert_macros.svh @@
// Assertion macros for the top-level RTL file of the download controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// The condition must hold at every clock edge out of reset.
`define DFU_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define DFU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define DFU_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define DFU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/core/dfu_pkg.sv @@
// Package with codes, constants and control structs of the download controller.
`default_nettype none
package dfu_pkg;

    // Request codes.
    localparam logic [3:0] ACT_SET_INFO = 4'd0;
    localparam logic [3:0] ACT_ABORT    = 4'd1;
    localparam logic [3:0] ACT_CHECK    = 4'd2;
    localparam logic [3:0] ACT_UPDATE   = 4'd3;
    localparam logic [3:0] ACT_SYNC     = 4'd4;
    localparam logic [3:0] ACT_GET_STAT = 4'd5;
    localparam logic [3:0] ACT_GET_ST   = 4'd6;
    localparam logic [3:0] ACT_CHUNK    = 4'd7;

    // Protocol states.
    localparam logic [2:0] ST_DETACHED = 3'd0;
    localparam logic [2:0] ST_IDLE     = 3'd1;
    localparam logic [2:0] ST_DN_IDLE  = 3'd2;
    localparam logic [2:0] ST_DN_BUSY  = 3'd3;
    localparam logic [2:0] ST_DN_SYNC  = 3'd4;
    localparam logic [2:0] ST_UPD_BUSY = 3'd6;

    // Status codes.
    localparam logic [3:0] S_OK      = 4'd0;
    localparam logic [3:0] S_STATE   = 4'd1;
    localparam logic [3:0] S_TARGET  = 4'd3;
    localparam logic [3:0] S_FILE    = 4'd4;
    localparam logic [3:0] S_WRITE   = 4'd5;
    localparam logic [3:0] S_VERIFY  = 4'd6;
    localparam logic [3:0] S_INVAL   = 4'd8;
    localparam logic [3:0] S_UNKNOWN = 4'd10;

    // Stream and file commands.
    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_OPEN  = 2'd1;
    localparam logic [1:0] CMD_CLOSE = 2'd2;

    localparam logic [15:0] INFO_LEN         = 16'd64;
    localparam logic [2:0]  STATUS_REPLY_LEN = 3'd6;
    localparam logic [2:0]  STATE_REPLY_LEN  = 3'd1;
    localparam int          DEF_MAX_CHUNK    = 4096;
    localparam int          CNT_W            = 33;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic exec;
        logic mod_step;
        logic fin;
        logic load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_chk;
    } t_dp_sts;

endpackage
`default_nettype wire

@@ rtl/core/dfu_if.sv @@
// Item channel interfaces for requests and results.
`default_nettype none
interface dfu_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  action;
    logic [15:0] payload_length;
    logic [31:0] image_len;
    logic [31:0] sync_block_len;
    logic [63:0] free_bytes;
    logic        file_open_ok;
    logic        pipe_open_ok;
    logic        digest_match;
    logic [12:0] chunk_length;
    logic        write_ok;

    modport source (output valid, action, payload_length, image_len, sync_block_len,
                    free_bytes, file_open_ok, pipe_open_ok, digest_match, chunk_length,
                    write_ok, input ready);
    modport sink (input valid, action, payload_length, image_len, sync_block_len,
                  free_bytes, file_open_ok, pipe_open_ok, digest_match, chunk_length,
                  write_ok, output ready);
endinterface

interface dfu_out_if;
    logic        valid;
    logic        ready;
    logic        reply_valid;
    logic [2:0]  reply_length;
    logic [3:0]  reply_status;
    logic [2:0]  reply_state;
    logic [31:0] reply_written_bytes;
    logic [2:0]  state_now;
    logic [3:0]  status_now;
    logic [1:0]  stream_cmd;
    logic [1:0]  file_cmd;
    logic        discard_image;

    modport source (output valid, reply_valid, reply_length, reply_status, reply_state,
                    reply_written_bytes, state_now, status_now, stream_cmd, file_cmd,
                    discard_image, input ready);
    modport sink (input valid, reply_valid, reply_length, reply_status, reply_state,
                  reply_written_bytes, state_now, status_now, stream_cmd, file_cmd,
                  discard_image, output ready);
endinterface
`default_nettype wire

@@ rtl/core/dfu_ctrl.sv @@
// Controller state machine that sequences one item through the datapath.
`default_nettype none
module dfu_ctrl (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  wire             i_out_ready,
    input  dfu_pkg::t_dp_sts i_sts,
    output dfu_pkg::t_dp_cmd o_cmd
);
    localparam logic [2:0] C_IDLE = 3'd0;
    localparam logic [2:0] C_EXEC = 3'd1;
    localparam logic [2:0] C_MOD  = 3'd2;
    localparam logic [2:0] C_FIN  = 3'd3;
    localparam logic [2:0] C_DONE = 3'd4;
    localparam int STEP_W = $clog2(dfu_pkg::CNT_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(dfu_pkg::CNT_W - 1);

    logic [2:0]        r_fsm, n_fsm;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_out_valid, n_out_valid;
    logic              load_ok;

    assign o_in_ready  = (r_fsm == C_IDLE);
    assign o_out_valid = r_out_valid;
    assign load_ok     = !r_out_valid || i_out_ready;

    // Next state and commands.
    always_comb begin
        n_fsm       = r_fsm;
        n_step      = r_step;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        unique case (r_fsm)
            C_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_fsm         = C_EXEC;
                end
            end
            C_EXEC: begin
                o_cmd.exec = 1'b1;
                n_step     = '0;
                n_fsm      = i_sts.need_chk ? C_MOD : C_DONE;
            end
            C_MOD: begin
                o_cmd.mod_step = 1'b1;
                n_step         = r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    n_fsm = C_FIN;
                end
            end
            C_FIN: begin
                o_cmd.fin = 1'b1;
                n_fsm     = C_DONE;
            end
            C_DONE: begin
                if (load_ok) begin
                    o_cmd.load  = 1'b1;
                    n_out_valid = 1'b1;
                    n_fsm       = C_IDLE;
                end
            end
            default: begin
                n_fsm = C_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm       <= C_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_fsm       <= n_fsm;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end
endmodule
`default_nettype wire

@@ rtl/core/dfu_dp.sv @@
// Datapath: protocol state, request decoding, byte count and sync-block modulo.
`default_nettype none
module dfu_dp #(
    parameter int MAX_CHUNK = dfu_pkg::DEF_MAX_CHUNK
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  dfu_pkg::t_dp_cmd i_cmd,
    output dfu_pkg::t_dp_sts o_sts,
    dfu_in_if.sink           i_in,
    dfu_out_if.source        o_out
);
    localparam int MC_W  = $clog2(MAX_CHUNK + 1);
    localparam int CL_W  = (MC_W > 13) ? MC_W : 13;
    localparam int CNT_W = dfu_pkg::CNT_W;
    localparam logic [CL_W-1:0] MAX_CL = CL_W'(MAX_CHUNK);

    // Captured request.
    logic [3:0]  r_act;
    logic [15:0] r_plen;
    logic [31:0] r_isize, r_sbs;
    logic [63:0] r_free;
    logic        r_file_ok, r_pipe_ok, r_dig_ok, r_wr_ok;
    logic [12:0] r_clen;

    // Protocol state.
    logic [2:0]       r_state, n_state;
    logic [3:0]       r_status, n_status;
    logic [31:0]      r_exp, n_exp;
    logic [31:0]      r_blk, n_blk;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_open, n_open;

    // Per-item result fields.
    logic        r_rv, n_rv;
    logic [2:0]  r_rlen, n_rlen;
    logic [3:0]  r_rstat, n_rstat;
    logic [2:0]  r_rst, n_rst;
    logic [31:0] r_rwr, n_rwr;
    logic [1:0]  r_stream, n_stream, r_file, n_file;
    logic        r_disc, n_disc;

    // Modulo unit.
    logic [CNT_W-1:0] r_rem, r_quo, n_quo;
    logic [CNT_W-1:0] trial;
    logic             need_chk;

    logic [CL_W-1:0]  clen_ext, clen_cl;
    logic [CNT_W:0]   sum;
    logic [2:0]       st_len;

    assign clen_ext = CL_W'(r_clen);
    assign clen_cl  = (clen_ext > MAX_CL) ? MAX_CL : clen_ext;
    assign sum      = {1'b0, r_cnt} + (CNT_W + 1)'(clen_cl);
    assign st_len   = (r_plen < 16'(dfu_pkg::STATUS_REPLY_LEN))
                      ? r_plen[2:0] : dfu_pkg::STATUS_REPLY_LEN;
    assign o_sts.need_chk = need_chk;
    assign i_in.ready = 1'b0;

    // Request decoding and state update.
    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        n_exp    = r_exp;
        n_blk    = r_blk;
        n_cnt    = r_cnt;
        n_open   = r_open;
        n_rv     = 1'b0;
        n_rlen   = '0;
        n_rstat  = dfu_pkg::S_OK;
        n_rst    = '0;
        n_rwr    = '0;
        n_stream = dfu_pkg::CMD_NONE;
        n_file   = dfu_pkg::CMD_NONE;
        n_disc   = 1'b0;
        need_chk = 1'b0;
        case (r_act)
            dfu_pkg::ACT_SET_INFO: begin
                if (r_plen != dfu_pkg::INFO_LEN) begin
                    n_status = dfu_pkg::S_INVAL;
                end else if (r_state != dfu_pkg::ST_IDLE) begin
                    n_status = dfu_pkg::S_STATE;
                end else if ({32'd0, r_isize} >= r_free) begin
                    n_status = dfu_pkg::S_TARGET;
                end else begin
                    n_file = dfu_pkg::CMD_OPEN;
                    n_open = r_file_ok;
                    if (!r_file_ok) begin
                        n_status = dfu_pkg::S_FILE;
                    end else begin
                        n_exp    = r_isize;
                        n_blk    = r_sbs;
                        n_cnt    = '0;
                        n_stream = dfu_pkg::CMD_OPEN;
                        if (!r_pipe_ok) begin
                            n_status = dfu_pkg::S_UNKNOWN;
                        end else begin
                            n_state  = dfu_pkg::ST_DN_IDLE;
                            n_status = dfu_pkg::S_OK;
                        end
                    end
                end
            end
            dfu_pkg::ACT_ABORT: begin
                if (r_state != dfu_pkg::ST_UPD_BUSY) begin
                    n_state = dfu_pkg::ST_IDLE;
                end
                n_stream = dfu_pkg::CMD_CLOSE;
                n_disc   = 1'b1;
                n_status = dfu_pkg::S_OK;
            end
            dfu_pkg::ACT_CHECK: begin
                if (r_state != dfu_pkg::ST_DN_IDLE) begin
                    n_status = dfu_pkg::S_STATE;
                end else begin
                    if (!r_dig_ok) begin
                        n_status = dfu_pkg::S_VERIFY;
                    end
                    if (r_open) begin
                        n_file = dfu_pkg::CMD_CLOSE;
                        n_open = 1'b0;
                    end
                    if (n_status == dfu_pkg::S_OK) begin
                        n_state = dfu_pkg::ST_IDLE;
                    end
                end
            end
            dfu_pkg::ACT_UPDATE: begin
                n_state = dfu_pkg::ST_UPD_BUSY;
            end
            dfu_pkg::ACT_SYNC: begin
                n_rv    = 1'b1;
                n_rlen  = st_len;
                n_rstat = r_status;
                n_rst   = r_state;
                n_rwr   = r_cnt[31:0];
                if (r_state != dfu_pkg::ST_DN_SYNC) begin
                    n_rstat = dfu_pkg::S_STATE;
                end else if (r_status == dfu_pkg::S_OK) begin
                    n_state = dfu_pkg::ST_DN_IDLE;
                    if (r_cnt >= CNT_W'(r_exp)) begin
                        if (r_open) begin
                            n_file = dfu_pkg::CMD_CLOSE;
                            n_open = 1'b0;
                        end
                        n_stream = dfu_pkg::CMD_CLOSE;
                    end
                end
            end
            dfu_pkg::ACT_GET_STAT: begin
                n_rv    = 1'b1;
                n_rlen  = st_len;
                n_rstat = r_status;
                n_rst   = r_state;
            end
            dfu_pkg::ACT_GET_ST: begin
                n_rv   = 1'b1;
                n_rlen = (r_plen < 16'(dfu_pkg::STATE_REPLY_LEN))
                         ? r_plen[2:0] : dfu_pkg::STATE_REPLY_LEN;
                n_rst  = r_state;
            end
            dfu_pkg::ACT_CHUNK: begin
                if (r_state != dfu_pkg::ST_DN_IDLE && r_state != dfu_pkg::ST_DN_BUSY) begin
                    n_status = dfu_pkg::S_STATE;
                end else begin
                    n_state = dfu_pkg::ST_DN_BUSY;
                    if (!r_open) begin
                        n_status = dfu_pkg::S_FILE;
                    end else if (r_clen != 13'd0) begin
                        if (!r_wr_ok) begin
                            n_state  = dfu_pkg::ST_DN_SYNC;
                            n_status = dfu_pkg::S_WRITE;
                        end else begin
                            // Saturate the count, then check the sync point.
                            n_cnt    = sum[CNT_W] ? '1 : sum[CNT_W-1:0];
                            need_chk = 1'b1;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // One restoring modulo step: shift in a dividend bit, subtract if it fits.
    assign trial = {r_rem[CNT_W-2:0], r_quo[CNT_W-1]};
    assign n_quo = {r_quo[CNT_W-2:0], 1'b0};

    // Captured request, result fields and modulo registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_act     <= i_in.action;
            r_plen    <= i_in.payload_length;
            r_isize   <= i_in.image_len;
            r_sbs     <= i_in.sync_block_len;
            r_free    <= i_in.free_bytes;
            r_file_ok <= i_in.file_open_ok;
            r_pipe_ok <= i_in.pipe_open_ok;
            r_dig_ok  <= i_in.digest_match;
            r_clen    <= i_in.chunk_length;
            r_wr_ok   <= i_in.write_ok;
        end
        if (i_cmd.exec) begin
            r_rv     <= n_rv;
            r_rlen   <= n_rlen;
            r_rstat  <= n_rstat;
            r_rst    <= n_rst;
            r_rwr    <= n_rwr;
            r_stream <= n_stream;
            r_file   <= n_file;
            r_disc   <= n_disc;
            r_rem    <= '0;
            r_quo    <= n_cnt;
        end else if (i_cmd.mod_step) begin
            r_rem <= (trial >= CNT_W'(r_blk)) ? trial - CNT_W'(r_blk) : trial;
            r_quo <= n_quo;
        end
    end

    // Protocol state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= dfu_pkg::ST_DETACHED;
            r_status <= dfu_pkg::S_OK;
            r_exp    <= '0;
            r_blk    <= '0;
            r_cnt    <= '0;
            r_open   <= 1'b0;
        end else if (i_cmd.exec) begin
            r_state  <= n_state;
            r_status <= n_status;
            r_exp    <= n_exp;
            r_blk    <= n_blk;
            r_cnt    <= n_cnt;
            r_open   <= n_open;
        end else if (i_cmd.fin) begin
            if ((r_blk != 32'd0 && r_cnt != '0 && r_rem == '0) ||
                r_cnt >= CNT_W'(r_exp)) begin
                r_state <= dfu_pkg::ST_DN_SYNC;
            end
        end
    end

    // Output register, loaded when the item is finished.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            o_out.reply_valid         <= r_rv;
            o_out.reply_length        <= r_rlen;
            o_out.reply_status        <= r_rstat;
            o_out.reply_state         <= r_rst;
            o_out.reply_written_bytes <= r_rwr;
            o_out.state_now           <= r_state;
            o_out.status_now          <= r_status;
            o_out.stream_cmd          <= r_stream;
            o_out.file_cmd            <= r_file;
            o_out.discard_image       <= r_disc;
        end
    end
endmodule
`default_nettype wire

@@ rtl/core/dfu_download_controller.sv @@
// Each item passes IDLE (capture), EXEC and DONE (load); a stored data chunk adds MOD and FIN.
// A stored chunk runs a 33-step bit-serial modulo of the byte count by the sync block size.
// One item at a time: the next one is taken from the cycle after the result is loaded,
// and DONE waits to load while the output register holds a result not yet taken.
// A finished result waits in the output register while the next item is accepted.
// Reset (synchronous, active low) sets state DETACHED, status OK, counts and sizes to zero.
`default_nettype none
`include "assert_macros.svh"
module dfu_download_controller #(
    parameter int MAX_CHUNK = dfu_pkg::DEF_MAX_CHUNK
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    dfu_in_if.sink    i_in,
    dfu_out_if.source o_out
);
    dfu_pkg::t_dp_cmd cmd;
    dfu_pkg::t_dp_sts sts;
    logic             in_ready;
    logic             out_valid;

    // Sequencer.
    dfu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Datapath; its ready output is held low, so the sequencer alone decides ready.
    dfu_in_if dp_in ();
    assign dp_in.valid           = i_in.valid;
    assign dp_in.action          = i_in.action;
    assign dp_in.payload_length  = i_in.payload_length;
    assign dp_in.image_len       = i_in.image_len;
    assign dp_in.sync_block_len  = i_in.sync_block_len;
    assign dp_in.free_bytes      = i_in.free_bytes;
    assign dp_in.file_open_ok    = i_in.file_open_ok;
    assign dp_in.pipe_open_ok    = i_in.pipe_open_ok;
    assign dp_in.digest_match    = i_in.digest_match;
    assign dp_in.chunk_length    = i_in.chunk_length;
    assign dp_in.write_ok        = i_in.write_ok;

    dfu_dp #(.MAX_CHUNK(MAX_CHUNK)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .i_in    (dp_in),
        .o_out   (o_out)
    );

    assign i_in.ready  = in_ready && !dp_in.ready;
    assign o_out.valid = out_valid;

    // Checks.
    `DFU_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, i_in.valid && i_in.ready, !i_in.ready)
    `DFU_ASSERT_ALWAYS(a_state_code, i_clk, i_rst_n,
        !o_out.valid || (o_out.state_now != 3'd5 && o_out.state_now != 3'd7))
    `DFU_ASSERT_ALWAYS(a_no_reply, i_clk, i_rst_n,
        !o_out.valid || o_out.reply_valid || (o_out.reply_length == 3'd0))
    `DFU_ASSERT_ALWAYS(a_cmd_code, i_clk, i_rst_n,
        !o_out.valid || (o_out.stream_cmd != 2'd3 && o_out.file_cmd != 2'd3))
endmodule
`default_nettype wire

@@ sim/dfu_download_controller_checker.sv @@
// Checker that predicts each download-controller result and compares it with the block.
`timescale 1ns / 1ps
`default_nettype none
module dfu_download_controller_checker (
    input  wire        i_clk,
    input  wire        i_rst_n,
    dfu_in_if          i_in,
    dfu_out_if         i_out,
    output logic [31:0] o_fail_count,
    output logic [31:0] o_pending
);
    localparam logic [32:0] COUNT_SAT = {33{1'b1}};

    // One predicted result item.
    typedef struct packed {
        logic        reply_valid;
        logic [2:0]  reply_length;
        logic [3:0]  reply_status;
        logic [2:0]  reply_state;
        logic [31:0] reply_written_bytes;
        logic [2:0]  state_now;
        logic [3:0]  status_now;
        logic [1:0]  stream_cmd;
        logic [1:0]  file_cmd;
        logic        discard_image;
    } t_result;

    // Predicted protocol state.
    logic [2:0]  dl_state;
    logic [3:0]  dl_status;
    logic [31:0] dl_image_len;
    logic [31:0] dl_block_len;
    logic [32:0] dl_written;
    logic        dl_target_open;

    t_result expected_results[$];
    int unsigned mismatch_count;

    function automatic logic [2:0] clip_len(logic [15:0] req, logic [2:0] size);
        return (req < 16'(size)) ? req[2:0] : size;
    endfunction

    // Advance the predicted state by one request and return the expected result.
    function automatic t_result download_step(
        logic [3:0] action, logic [15:0] plen, logic [31:0] isize, logic [31:0] sbs,
        logic [63:0] free_sp, logic file_ok, logic pipe_ok, logic digest_ok,
        logic [12:0] clen, logic wr_ok);
        t_result r;
        logic [12:0] bytes;
        logic [33:0] sum;
        r = '0;
        case (action)
            dfu_pkg::ACT_SET_INFO: begin
                if (plen != dfu_pkg::INFO_LEN) begin
                    dl_status = dfu_pkg::S_INVAL;
                end else if (dl_state != dfu_pkg::ST_IDLE) begin
                    dl_status = dfu_pkg::S_STATE;
                end else if (64'(isize) >= free_sp) begin
                    dl_status = dfu_pkg::S_TARGET;
                end else begin
                    r.file_cmd = dfu_pkg::CMD_OPEN;
                    dl_target_open = file_ok;
                    if (!file_ok) begin
                        dl_status = dfu_pkg::S_FILE;
                    end else begin
                        dl_image_len = isize;
                        dl_block_len = sbs;
                        dl_written = '0;
                        r.stream_cmd = dfu_pkg::CMD_OPEN;
                        if (!pipe_ok) begin
                            dl_status = dfu_pkg::S_UNKNOWN;
                        end else begin
                            dl_state = dfu_pkg::ST_DN_IDLE;
                            dl_status = dfu_pkg::S_OK;
                        end
                    end
                end
            end
            dfu_pkg::ACT_ABORT: begin
                if (dl_state != dfu_pkg::ST_UPD_BUSY) dl_state = dfu_pkg::ST_IDLE;
                r.stream_cmd = dfu_pkg::CMD_CLOSE;
                r.discard_image = 1'b1;
                dl_status = dfu_pkg::S_OK;
            end
            dfu_pkg::ACT_CHECK: begin
                if (dl_state != dfu_pkg::ST_DN_IDLE) begin
                    dl_status = dfu_pkg::S_STATE;
                end else begin
                    if (!digest_ok) dl_status = dfu_pkg::S_VERIFY;
                    if (dl_target_open) begin
                        r.file_cmd = dfu_pkg::CMD_CLOSE;
                        dl_target_open = 1'b0;
                    end
                    if (dl_status == dfu_pkg::S_OK) dl_state = dfu_pkg::ST_IDLE;
                end
            end
            dfu_pkg::ACT_UPDATE: dl_state = dfu_pkg::ST_UPD_BUSY;
            dfu_pkg::ACT_SYNC: begin
                r.reply_valid = 1'b1;
                r.reply_length = clip_len(plen, dfu_pkg::STATUS_REPLY_LEN);
                r.reply_status = dl_status;
                r.reply_state = dl_state;
                r.reply_written_bytes = dl_written[31:0];
                if (dl_state != dfu_pkg::ST_DN_SYNC) begin
                    r.reply_status = dfu_pkg::S_STATE;
                end else if (dl_status == dfu_pkg::S_OK) begin
                    dl_state = dfu_pkg::ST_DN_IDLE;
                    if (dl_written >= 33'(dl_image_len)) begin
                        if (dl_target_open) begin
                            r.file_cmd = dfu_pkg::CMD_CLOSE;
                            dl_target_open = 1'b0;
                        end
                        r.stream_cmd = dfu_pkg::CMD_CLOSE;
                    end
                end
            end
            dfu_pkg::ACT_GET_STAT: begin
                r.reply_valid = 1'b1;
                r.reply_length = clip_len(plen, dfu_pkg::STATUS_REPLY_LEN);
                r.reply_status = dl_status;
                r.reply_state = dl_state;
            end
            dfu_pkg::ACT_GET_ST: begin
                r.reply_valid = 1'b1;
                r.reply_length = clip_len(plen, dfu_pkg::STATE_REPLY_LEN);
                r.reply_state = dl_state;
            end
            dfu_pkg::ACT_CHUNK: begin
                if (dl_state != dfu_pkg::ST_DN_IDLE && dl_state != dfu_pkg::ST_DN_BUSY) begin
                    dl_status = dfu_pkg::S_STATE;
                end else begin
                    dl_state = dfu_pkg::ST_DN_BUSY;
                    if (!dl_target_open) begin
                        dl_status = dfu_pkg::S_FILE;
                    end else if (clen != 0) begin
                        if (!wr_ok) begin
                            dl_state = dfu_pkg::ST_DN_SYNC;
                            dl_status = dfu_pkg::S_WRITE;
                        end else begin
                            bytes = (clen > 13'(dfu_pkg::DEF_MAX_CHUNK))
                                    ? 13'(dfu_pkg::DEF_MAX_CHUNK) : clen;
                            sum = 34'(dl_written) + 34'(bytes);
                            dl_written = sum[33] ? COUNT_SAT : sum[32:0];
                            if (dl_block_len != 0 && dl_written != 0 &&
                                dl_written % 33'(dl_block_len) == 0)
                                dl_state = dfu_pkg::ST_DN_SYNC;
                            else if (dl_written >= 33'(dl_image_len))
                                dl_state = dfu_pkg::ST_DN_SYNC;
                        end
                    end
                end
            end
            default: ;
        endcase
        r.state_now = dl_state;
        r.status_now = dl_status;
        return r;
    endfunction

    // Predict on each accepted request; compare each accepted result.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            dl_state = dfu_pkg::ST_DETACHED;
            dl_status = dfu_pkg::S_OK;
            dl_image_len = '0;
            dl_block_len = '0;
            dl_written = '0;
            dl_target_open = 1'b0;
            expected_results.delete();
            mismatch_count = 0;
        end else begin
            if (i_in.valid && i_in.ready)
                expected_results.push_back(download_step(i_in.action, i_in.payload_length,
                    i_in.image_len, i_in.sync_block_len, i_in.free_bytes,
                    i_in.file_open_ok, i_in.pipe_open_ok, i_in.digest_match,
                    i_in.chunk_length, i_in.write_ok));
            if (i_out.valid && i_out.ready) begin
                got = '{i_out.reply_valid, i_out.reply_length, i_out.reply_status,
                        i_out.reply_state, i_out.reply_written_bytes, i_out.state_now,
                        i_out.status_now, i_out.stream_cmd, i_out.file_cmd,
                        i_out.discard_image};
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result item %h", got);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: expected %p actual %p", want, got);
                    end
                end
            end
        end
    end

    assign o_fail_count = mismatch_count;
    assign o_pending = 32'(expected_results.size());
endmodule
`default_nettype wire

@@ sim/dfu_download_controller_tb.sv @@
// Top of the download-controller testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
`default_nettype none
module dfu_download_controller_tb;
    localparam logic [3:0] ACT_OTHER = 4'd8;
    localparam logic [3:0] ACT_LAST  = 4'd15;

    logic i_clk;
    logic i_rst_n;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   hold_off_cycles;
    int   sent_count;
    logic [31:0] fail_count;
    logic [31:0] pending;

    dfu_in_if  req_ch ();
    dfu_out_if res_ch ();

    dfu_download_controller dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch.sink),
        .o_out   (res_ch.source)
    );

    dfu_download_controller_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (req_ch),
        .i_out        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Result side: random stalls, or a long hold-off when one is requested.
    initial res_ch.ready = 1'b0;
    always @(posedge i_clk) begin
        if (hold_off_cycles > 0) begin
            res_ch.ready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end else begin
            res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Drive one request item and wait until it is taken.
    task automatic send_request(logic [3:0] action, logic [15:0] plen, logic [31:0] isize,
                                logic [31:0] sbs, logic [63:0] free_sp, logic file_ok,
                                logic pipe_ok, logic digest_ok, logic [12:0] clen,
                                logic wr_ok);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.action <= action;
        req_ch.payload_length <= plen;
        req_ch.image_len <= isize;
        req_ch.sync_block_len <= sbs;
        req_ch.free_bytes <= free_sp;
        req_ch.file_open_ok <= file_ok;
        req_ch.pipe_open_ok <= pipe_ok;
        req_ch.digest_match <= digest_ok;
        req_ch.chunk_length <= clen;
        req_ch.write_ok <= wr_ok;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        sent_count++;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Any request with fully random fields.
    task automatic send_noise();
        send_request(4'($urandom_range(15)), 16'($urandom()), $urandom(), $urandom(),
                     rand64(), 1'($urandom()), 1'($urandom()), 1'($urandom()),
                     13'($urandom()), 1'($urandom()));
    endtask

    task automatic send_simple(logic [3:0] action, logic [15:0] plen);
        send_request(action, plen, $urandom(), $urandom(), rand64(), 1'($urandom()),
                     1'($urandom()), 1'($urandom()), 13'($urandom()), 1'($urandom()));
    endtask

    // A full download: abort (to idle unless an update is busy), set info, chunks with syncs, check.
    task automatic send_session(int chunks);
        logic [31:0] isize;
        logic [31:0] sbs;
        logic [12:0] clen;
        logic [63:0] free_sp;
        isize = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(20000);
        case ($urandom_range(3))
            0: sbs = '0;
            1: sbs = $urandom_range(1, 64);
            2: sbs = $urandom_range(1, 9000);
            default: sbs = $urandom();
        endcase
        free_sp = ($urandom_range(9) == 0) ? 64'($urandom_range(20000))
                                           : rand64() | 64'h1_0000_0000;
        send_simple(dfu_pkg::ACT_ABORT, 16'($urandom()));
        send_request(dfu_pkg::ACT_SET_INFO, dfu_pkg::INFO_LEN, isize, sbs, free_sp,
                     $urandom_range(15) != 0, $urandom_range(15) != 0, 1'($urandom()),
                     13'($urandom()), 1'($urandom()));
        repeat (chunks) begin
            case ($urandom_range(9))
                0: clen = 13'($urandom());
                1: clen = '0;
                default: clen = 13'($urandom_range(1, 4096));
            endcase
            send_request(dfu_pkg::ACT_CHUNK, 16'($urandom()), $urandom(), $urandom(),
                         rand64(), 1'($urandom()), 1'($urandom()), 1'($urandom()), clen,
                         $urandom_range(19) != 0);
            if ($urandom_range(3) != 0)
                send_simple(dfu_pkg::ACT_SYNC, 16'($urandom_range(8)));
            if ($urandom_range(5) == 0)
                send_simple(4'($urandom_range(dfu_pkg::ACT_GET_STAT, dfu_pkg::ACT_GET_ST)),
                            16'($urandom_range(8)));
        end
        send_request(dfu_pkg::ACT_CHECK, 16'($urandom()), $urandom(), $urandom(), rand64(),
                     1'($urandom()), 1'($urandom()), $urandom_range(3) != 0,
                     13'($urandom()), 1'($urandom()));
    endtask

    task automatic run_random(int items);
        int stop_at;
        stop_at = sent_count + items;
        while (sent_count < stop_at) begin
            if ($urandom_range(4) == 0)
                send_noise();
            else
                send_session(4);
        end
    endtask

    initial begin
        req_ch.valid = 1'b0;
        req_ch.action = '0;
        req_ch.payload_length = '0;
        req_ch.image_len = '0;
        req_ch.sync_block_len = '0;
        req_ch.free_bytes = '0;
        req_ch.file_open_ok = 1'b0;
        req_ch.pipe_open_ok = 1'b0;
        req_ch.digest_match = 1'b0;
        req_ch.chunk_length = '0;
        req_ch.write_ok = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        sent_count = 0;
        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: requests in the detached state, unknown action, zero-length reply.
        send_simple(dfu_pkg::ACT_GET_ST, 16'd0);
        send_simple(dfu_pkg::ACT_SYNC, 16'hFFFF);
        send_simple(ACT_LAST, 16'd64);
        send_simple(ACT_OTHER, 16'd64);
        send_simple(dfu_pkg::ACT_CHUNK, 16'd1);
        send_request(dfu_pkg::ACT_SET_INFO, 16'd63, '1, '1, '1, 1'b1, 1'b1, 1'b1, '1, 1'b1);
        send_simple(dfu_pkg::ACT_ABORT, 16'd0);
        // Image too large, open failure, pipe failure, then a good set info.
        send_request(dfu_pkg::ACT_SET_INFO, dfu_pkg::INFO_LEN, 32'd100, '0, 64'd100,
                     1'b1, 1'b1, 1'b1, '0, 1'b1);
        send_request(dfu_pkg::ACT_SET_INFO, dfu_pkg::INFO_LEN, 32'd100, '0, 64'd101,
                     1'b0, 1'b1, 1'b1, '0, 1'b1);
        send_simple(dfu_pkg::ACT_CHUNK, 16'd1);
        send_simple(dfu_pkg::ACT_ABORT, 16'd1);
        send_request(dfu_pkg::ACT_SET_INFO, dfu_pkg::INFO_LEN, 32'd100, '0, 64'd101,
                     1'b1, 1'b0, 1'b1, '0, 1'b1);
        send_request(dfu_pkg::ACT_SET_INFO, dfu_pkg::INFO_LEN, '1, 32'd4096, '1,
                     1'b1, 1'b1, 1'b1, '0, 1'b1);
        send_request(dfu_pkg::ACT_CHUNK, '0, '0, '0, '0, 1'b0, 1'b0, 1'b0, 13'd0, 1'b1);
        send_request(dfu_pkg::ACT_CHUNK, '0, '0, '0, '0, 1'b0, 1'b0, 1'b0, 13'h1FFF, 1'b1);
        send_simple(dfu_pkg::ACT_GET_STAT, 16'd6);
        send_simple(dfu_pkg::ACT_SYNC, 16'd7);
        send_request(dfu_pkg::ACT_CHUNK, '0, '0, '0, '0, 1'b0, 1'b0, 1'b0, 13'd1, 1'b0);
        send_simple(dfu_pkg::ACT_SYNC, 16'd3);
        send_request(dfu_pkg::ACT_CHECK, '0, '0, '0, '0, 1'b0, 1'b0, 1'b0, '0, 1'b0);
        send_simple(dfu_pkg::ACT_ABORT, 16'd0);
        send_request(dfu_pkg::ACT_CHECK, '0, '0, '0, '0, 1'b0, 1'b0, 1'b1, '0, 1'b0);
        send_simple(dfu_pkg::ACT_UPDATE, 16'd0);
        send_simple(dfu_pkg::ACT_ABORT, 16'd0);

        // Random phases with different idling, then a long receiver hold-off.
        run_random(300);
        send_idle_pct = 86;
        run_random(250);
        send_idle_pct = 0;
        recv_stall_pct = 86;
        run_random(250);
        send_idle_pct = 23;
        recv_stall_pct = 23;
        run_random(250);
        hold_off_cycles = 400;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        run_random(320);
        req_ch.valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0)
            $display("dfu_download_controller_tb passed");
        else
            $display("dfu_download_controller_tb failed");
        $finish;
    end

    initial begin
        #4000000;
        $display("dfu_download_controller_tb failed");
        $finish;
    end
endmodule
`default_nettype wire

@@ filelist.f @@
+incdir+rtl/core
rtl/core/dfu_pkg.sv
rtl/core/dfu_if.sv
rtl/core/dfu_ctrl.sv
rtl/core/dfu_dp.sv
rtl/core/dfu_download_controller.sv
sim/dfu_download_controller_checker.sv
sim/dfu_download_controller_tb.sv
